@@ rtl/core/snake_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snake activation package
// Shared sizes, fixed-point constants, codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package snake_pkg;

  // Storage and iteration counts.
  localparam int CHANNELS     = 256;
  localparam int CORDIC_STEPS = 16;
  localparam int CH_AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths.
  localparam int CH_W    = 8;
  localparam int CNT_W   = 9;
  localparam int VAL_W   = 24;
  localparam int ALPHA_W = 20;
  localparam int RECIP_W = 24;
  localparam int MAG_W   = 44;
  localparam int SQ_W    = 31;

  // Pipeline depths: the divider yields one quotient bit per stage, the sine
  // path needs seven stages around the CORDIC. Both meet at the table port.
  localparam int DIV_BITS  = RECIP_W;
  localparam int SINE_LAT  = CORDIC_STEPS + 7;
  localparam int MEM_STAGE = (SINE_LAT > DIV_BITS) ? SINE_LAT : DIV_BITS;

  // 2^32 >> DIV_BITS: the top of the dividend, and the largest alpha whose
  // reciprocal saturates.
  localparam int DIV_NUM_TOP = 256;

  // Phase reduction constants (Q.32) and the reciprocal of pi for the
  // quotient estimate, scaled by 2^(PI_RECIP_SHIFT + MAG_HI_LSB - 32).
  localparam logic [33:0] PI_Q32         = 34'd13493037705;
  localparam logic [33:0] HALF_PI_Q32    = 34'd6746518852;
  localparam logic [15:0] PI_RECIP       = 16'd41721;
  localparam int          PI_RECIP_SHIFT = 27;
  localparam int          MAG_HI_LSB     = 22;

  // CORDIC start value, Q2.30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;
  localparam logic [RECIP_W-1:0] RECIP_MAX = '1;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_ALPHA = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Truncated arctangents of 2^-i in Q2.30.
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'h3243F6A8;
      1:  a = 32'h1DAC6705;
      2:  a = 32'h0FADBAFC;
      3:  a = 32'h07F56EA6;
      4:  a = 32'h03FEAB76;
      5:  a = 32'h01FFD55B;
      6:  a = 32'h00FFFAAA;
      7:  a = 32'h007FFF55;
      8:  a = 32'h003FFFEA;
      9:  a = 32'h001FFFFD;
      10: a = 32'h000FFFFF;
      11: a = 32'h0007FFFF;
      12: a = 32'h0003FFFF;
      13: a = 32'h0001FFFF;
      14: a = 32'h0000FFFF;
      15: a = 32'h00007FFF;
      16: a = 32'h00003FFF;
      17: a = 32'h00001FFF;
      18: a = 32'h00000FFF;
      19: a = 32'h000007FF;
      20: a = 32'h000003FF;
      21: a = 32'h000001FF;
      22: a = 32'h000000FF;
      23: a = 32'h0000007F;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/snake_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snake reciprocal divider
// Pipelined restoring division giving round(2^32 / alpha) for alpha above
// the saturation limit, one quotient bit per stage, padded to the table stage.
// ----------------------------------------------------------------------------
module snake_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [snake_pkg::ALPHA_W-1:0]  den_i,
  output logic [snake_pkg::RECIP_W-1:0]  quo_o
);
  import snake_pkg::*;

  logic [ALPHA_W-1:0]  rem_q [1:DIV_BITS];
  logic [ALPHA_W-1:0]  den_q [1:DIV_BITS];
  logic [DIV_BITS-1:0] num_q [1:DIV_BITS];
  logic [DIV_BITS-1:0] quo_q [1:MEM_STAGE];

  for (genvar k = 0; k < MEM_STAGE; k++) begin : g_stage
    if (k < DIV_BITS) begin : g_step
      logic [ALPHA_W-1:0]  rem_in;
      logic [ALPHA_W-1:0]  den_in;
      logic [DIV_BITS-1:0] num_in;
      logic [DIV_BITS-1:0] quo_in;
      logic [ALPHA_W:0]    trial;
      logic [ALPHA_W:0]    diff;
      logic                fits;

      // The first stage starts from the dividend 2^32 + alpha/2.
      if (k == 0) begin : g_first
        assign rem_in = ALPHA_W'(DIV_NUM_TOP);
        assign den_in = den_i;
        assign num_in = DIV_BITS'(den_i >> 1);
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[k];
        assign den_in = den_q[k];
        assign num_in = num_q[k];
        assign quo_in = quo_q[k];
      end

      // Bring down one dividend bit and subtract where it fits.
      assign trial = {rem_in, num_in[DIV_BITS-1]};
      assign diff  = trial - {1'b0, den_in};
      assign fits  = (trial >= {1'b0, den_in});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= fits ? diff[ALPHA_W-1:0] : trial[ALPHA_W-1:0];
          den_q[k+1] <= den_in;
          num_q[k+1] <= num_in << 1;
          quo_q[k+1] <= {quo_in[DIV_BITS-2:0], fits};
        end
      end
    end else begin : g_pad
      // Delay the finished quotient up to the table stage.
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[k+1] <= quo_q[k];
        end
      end
    end
  end

  assign quo_o = quo_q[MEM_STAGE];

endmodule

@@ rtl/core/snake_sine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snake sine-squared pipeline
// Forms alpha*|x|, reduces it modulo pi, folds it to [0, pi/2], runs a
// pipelined rotation CORDIC and squares the clamped sine into Q.30.
// ----------------------------------------------------------------------------
module snake_sine (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [snake_pkg::ALPHA_W-1:0] alpha_i,
  input  logic [snake_pkg::VAL_W-1:0]   vmag_i,
  output logic [snake_pkg::SQ_W-1:0]    sq_o
);
  import snake_pkg::*;

  localparam int XY_W   = 34;
  localparam int Z_W    = 33;
  localparam int QEST_W = 11;
  localparam int QP_W   = MAG_W - MAG_HI_LSB + 16;
  localparam logic signed [XY_W-1:0] ONE_Q30 = 34'sd1073741824;

  logic [MAG_W-1:0]     mag_q, mag2_q, mag3_q, prod_q;
  logic [QEST_W-1:0]    qest_q;
  logic [34:0]          r0_q;
  logic [33:0]          r1_q;
  logic signed [Z_W-1:0] z0_q;

  logic [QP_W-1:0]  qprod;
  logic [33:0]      rfold;
  logic [33:0]      rround;

  logic signed [XY_W-1:0] cx_q [1:CORDIC_STEPS];
  logic signed [XY_W-1:0] cy_q [1:CORDIC_STEPS];
  logic signed [Z_W-1:0]  cz_q [1:CORDIC_STEPS];

  logic [SQ_W-1:0]  sq_q [SINE_LAT:MEM_STAGE];
  logic [30:0]      sclamp;
  logic [61:0]      ssq;

  // Quotient estimate from the top bits of the phase; never above the true one.
  assign qprod = QP_W'(mag_q[MAG_W-1:MAG_HI_LSB]) * QP_W'(PI_RECIP);

  // Fold into [0, pi/2] and round from Q.32 to Q2.30.
  assign rfold  = (r1_q > HALF_PI_Q32) ? (PI_Q32 - r1_q) : r1_q;
  assign rround = rfold + 34'd2;

  // Phase product, reduction modulo pi and the fold.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= MAG_W'(alpha_i) * MAG_W'(vmag_i);
      mag2_q <= mag_q;
      qest_q <= qprod[PI_RECIP_SHIFT +: QEST_W];
      mag3_q <= mag2_q;
      prod_q <= MAG_W'(qest_q) * MAG_W'(PI_Q32);
      r0_q   <= 35'(mag3_q - prod_q);
      r1_q   <= (r0_q >= 35'(PI_Q32)) ? 34'(r0_q - 35'(PI_Q32)) : r0_q[33:0];
      z0_q   <= $signed({1'b0, rround[33:2]});
    end
  end

  // One CORDIC iteration per stage.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic signed [Z_W-1:0]  angle;

    if (k == 0) begin : g_first
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = z0_q;
    end else begin : g_next
      assign x_in = cx_q[k];
      assign y_in = cy_q[k];
      assign z_in = cz_q[k];
    end

    assign angle = $signed(Z_W'(atan_q30(k)));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_in >= 0) begin
          cx_q[k+1] <= x_in - (y_in >>> k);
          cy_q[k+1] <= y_in + (x_in >>> k);
          cz_q[k+1] <= z_in - angle;
        end else begin
          cx_q[k+1] <= x_in + (y_in >>> k);
          cy_q[k+1] <= y_in - (x_in >>> k);
          cz_q[k+1] <= z_in + angle;
        end
      end
    end
  end

  // Clamp the sine to [0, 1] and square it.
  always_comb begin
    if (cy_q[CORDIC_STEPS] < 0) begin
      sclamp = '0;
    end else if (cy_q[CORDIC_STEPS] > ONE_Q30) begin
      sclamp = ONE_Q30[30:0];
    end else begin
      sclamp = cy_q[CORDIC_STEPS][30:0];
    end
  end

  assign ssq = 62'(sclamp) * 62'(sclamp);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[SINE_LAT] <= ssq[60:30];
    end
  end

  // Delay the square up to the table stage.
  for (genvar k = SINE_LAT; k < MEM_STAGE; k++) begin : g_pad
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k+1] <= sq_q[k];
      end
    end
  end

  assign sq_o = sq_q[MEM_STAGE];

endmodule

@@ rtl/core/snake_activation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snake activation
// Per-channel y = x + sin^2(alpha*x)/alpha with alpha and 1/alpha tables.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output is not stalled and
// returns one result word for each, in order. MEM_STAGE is the larger of
// the 24-stage reciprocal divider and the CORDIC path (CORDIC_STEPS + 7).
// The alpha table is written and read as a word enters; the reciprocal
// table is written and read at MEM_STAGE, so every word sees exactly the
// loads that came before it. A stall on the output halts the whole
// pipeline. Both tables are undefined after reset; a channel must be
// loaded before it is sampled.
// ----------------------------------------------------------------------------
module snake_activation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [snake_pkg::CH_W-1:0]          channel_i,
  input  logic signed [snake_pkg::VAL_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [snake_pkg::VAL_W-1:0]  y_o,
  output logic [1:0]                          status_o,
  input  logic                                cfg_we_i,
  input  logic [snake_pkg::CNT_W-1:0]         cfg_wdata_i
);
  import snake_pkg::*;

  localparam int LAST   = MEM_STAGE + 2;
  localparam int TERM_W = VAL_W + 1;
  localparam int TP_W   = SQ_W + RECIP_W;
  localparam int Y_TOP  = (1 << (VAL_W - 1)) - 1;

  typedef struct packed {
    logic                    is_load;
    logic                    oor;
    logic                    azero;
    logic                    store;
    logic                    rec_zero;
    logic                    rec_sat;
    logic [CH_W-1:0]         ch;
    logic signed [VAL_W-1:0] v;
    status_e                 st;
  } meta_t;

  logic                 adv, accept;
  logic [CNT_W-1:0]     active_channels_q;
  logic                 valid_q [0:LAST];
  meta_t                meta_q  [0:LAST];
  meta_t                meta_d, meta_s1, meta_l;

  logic                 v_pos, v_big, ch_ok, smp_ok, rec_sat;
  logic [ALPHA_W-1:0]   a_sat, a_q, alpha_rd_q;
  logic [VAL_W-1:0]     vmag_d, vmag_q;

  logic [ALPHA_W-1:0]   alpha_mem [CHANNELS];
  logic [RECIP_W-1:0]   recip_mem [CHANNELS];
  logic [RECIP_W-1:0]   recip_rd_q, recip_wd, quo;
  logic                 recip_we;
  logic [SQ_W-1:0]      sq, sq_q;
  logic [TP_W-1:0]      tprod;
  logic [TERM_W-1:0]    term_q;
  logic signed [VAL_W+1:0] ysum;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] y_q, y_d;
  status_e                 status_q, status_d;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_channels_q <= CNT_W'(CHANNELS);
    end else if (cfg_we_i) begin
      active_channels_q <= cfg_wdata_i;
    end
  end

  // Decode of the incoming word.
  always_comb begin
    v_pos   = (value_i > 0);
    v_big   = (value_i > $signed(VAL_W'(ALPHA_MAX)));
    if (!v_pos) begin
      a_sat = '0;
    end else if (v_big) begin
      a_sat = ALPHA_MAX;
    end else begin
      a_sat = value_i[ALPHA_W-1:0];
    end
    rec_sat = v_pos && (a_sat <= ALPHA_W'(DIV_NUM_TOP));
    ch_ok   = (32'(channel_i) < CHANNELS);
    smp_ok  = ({1'b0, channel_i} < active_channels_q) && ch_ok;
    vmag_d  = value_i[VAL_W-1] ? VAL_W'(-value_i) : VAL_W'(value_i);

    meta_d.is_load  = (cmd_e'(cmd_i) == CMD_LOAD);
    meta_d.oor      = (cmd_e'(cmd_i) == CMD_SAMPLE) && !smp_ok;
    meta_d.azero    = 1'b0;
    meta_d.store    = ch_ok;
    meta_d.rec_zero = !v_pos;
    meta_d.rec_sat  = rec_sat;
    meta_d.ch       = channel_i;
    meta_d.v        = value_i;
    if (!ch_ok) begin
      meta_d.st = ST_RANGE;
    end else if (!v_pos) begin
      meta_d.st = ST_ALPHA;
    end else if (v_big || rec_sat) begin
      meta_d.st = ST_SAT;
    end else begin
      meta_d.st = ST_OK;
    end
  end

  // Alpha table: loads write on entry, every word reads on entry.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (accept && meta_d.is_load && ch_ok) begin
        alpha_mem[CH_AW'(channel_i)] <= a_sat;
      end
      alpha_rd_q <= alpha_mem[CH_AW'(channel_i)];
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LAST; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
      for (int k = 1; k <= LAST; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // A zero alpha is known once the table has answered.
  always_comb begin
    meta_s1       = meta_q[0];
    meta_s1.azero = (alpha_rd_q == '0);
  end

  // Word payload travelling with the arithmetic.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= meta_d;
      a_q       <= a_sat;
      vmag_q    <= vmag_d;
      meta_q[1] <= meta_s1;
      for (int k = 2; k <= LAST; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  snake_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .den_i (a_q),
    .quo_o (quo)
  );

  snake_sine u_sine (
    .clk_i   (clk_i),
    .en_i    (adv),
    .alpha_i (alpha_rd_q),
    .vmag_i  (vmag_q),
    .sq_o    (sq)
  );

  // Reciprocal table: loads write and samples read at the same stage.
  assign meta_l   = meta_q[MEM_STAGE];
  assign recip_we = adv && valid_q[MEM_STAGE] && meta_l.is_load && meta_l.store;
  always_comb begin
    if (meta_l.rec_zero) begin
      recip_wd = '0;
    end else if (meta_l.rec_sat) begin
      recip_wd = RECIP_MAX;
    end else begin
      recip_wd = quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (recip_we) begin
        recip_mem[CH_AW'(meta_l.ch)] <= recip_wd;
      end
      recip_rd_q <= recip_mem[CH_AW'(meta_l.ch)];
    end
  end

  // Scale the square by 1/alpha, rounding half up to Q.16.
  assign tprod = TP_W'(sq_q) * TP_W'(recip_rd_q) + (TP_W'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q   <= sq;
      term_q <= tprod[30 +: TERM_W];
    end
  end

  // Final result selection and saturation.
  assign ysum = {{2{meta_q[LAST].v[VAL_W-1]}}, meta_q[LAST].v} + $signed({1'b0, term_q});

  always_comb begin
    if (meta_q[LAST].is_load) begin
      y_d      = '0;
      status_d = meta_q[LAST].st;
    end else if (meta_q[LAST].oor) begin
      y_d      = '0;
      status_d = ST_RANGE;
    end else if (meta_q[LAST].azero) begin
      y_d      = meta_q[LAST].v;
      status_d = ST_ALPHA;
    end else if (ysum > $signed((VAL_W+2)'(Y_TOP))) begin
      y_d      = {1'b0, {(VAL_W-1){1'b1}}};
      status_d = ST_SAT;
    end else if (ysum < -$signed((VAL_W+2)'(Y_TOP)) - 1) begin
      y_d      = {1'b1, {(VAL_W-1){1'b0}}};
      status_d = ST_SAT;
    end else begin
      y_d      = ysum[VAL_W-1:0];
      status_d = ST_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q      <= y_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_o         = y_q;
  assign status_o    = status_q;

endmodule
